// ===== design/cptiu_pkg.sv =====
package cptiu_pkg;

    // item commands
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // register window
    localparam logic [3:0] REG_PRA   = 4'd0;
    localparam logic [3:0] REG_PRB   = 4'd1;
    localparam logic [3:0] REG_DDRA  = 4'd2;
    localparam logic [3:0] REG_DDRB  = 4'd3;
    localparam logic [3:0] REG_TA_LO = 4'd4;
    localparam logic [3:0] REG_TA_HI = 4'd5;
    localparam logic [3:0] REG_TB_LO = 4'd6;
    localparam logic [3:0] REG_TB_HI = 4'd7;
    localparam logic [3:0] REG_SDR   = 4'd12;
    localparam logic [3:0] REG_ICR   = 4'd13;
    localparam logic [3:0] REG_CRA   = 4'd14;
    localparam logic [3:0] REG_CRB   = 4'd15;

    // control register bits
    localparam int CR_START    = 0;
    localparam int CR_ONESHOT  = 3;
    localparam int CR_LOAD     = 4;

    // interrupt control bits
    localparam int ICR_TA      = 0;
    localparam int ICR_TB      = 1;
    localparam int ICR_SETCLR  = 7;

    // port A bits feeding the serial lines
    localparam int PA_ATN      = 3;
    localparam int PA_CLK      = 4;
    localparam int PA_DATA     = 5;
    localparam int PA_CLK_IN   = 6;
    localparam int PA_DATA_IN  = 7;

    typedef struct packed {
        logic       wr_lo;
        logic       wr_hi;
        logic       wr_ctrl;
        logic       tick;
        logic [7:0] data;
        logic [7:0] cycles;
    } timer_ctl_t;

    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  control;
        logic        underrun;
    } timer_sts_t;

endpackage

// ===== design/cptiu_in_if.sv =====
interface cptiu_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [3:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] tick_cycles;
    logic       serial_data_line;
    logic       serial_clock_line;

    modport source (
        output valid, command, reg_index, write_data, tick_cycles,
               serial_data_line, serial_clock_line,
        input  ready
    );
    modport sink (
        input  valid, command, reg_index, write_data, tick_cycles,
               serial_data_line, serial_clock_line,
        output ready
    );
endinterface

// ===== design/cptiu_out_if.sv =====
interface cptiu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;
    logic       nmi_request;
    logic       ser_data_out;
    logic       ser_clock_out;
    logic       ser_atn_out;
    logic [1:0] video_bank;

    modport source (
        output valid, read_data, nmi_request, ser_data_out, ser_clock_out,
               ser_atn_out, video_bank,
        input  ready
    );
    modport sink (
        input  valid, read_data, nmi_request, ser_data_out, ser_clock_out,
               ser_atn_out, video_bank,
        output ready
    );
endinterface

// ===== design/cptiu_timer.sv =====
module cptiu_timer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cptiu_pkg::timer_ctl_t  ctl,
    output cptiu_pkg::timer_sts_t  sts
);
    import cptiu_pkg::*;

    logic [15:0]        latch_reg,   latch_next;
    logic signed [17:0] counter_reg, counter_next;
    logic [7:0]         control_reg, control_next;
    logic               run_reg,     run_next;
    logic               reload_reg,  reload_next;
    logic signed [17:0] diff;
    logic               expired;
    logic               underrun;

    // stored count never goes negative, so diff stays above -256
    assign diff    = counter_reg - $signed({10'd0, ctl.cycles});
    assign expired = diff[17] || (diff == 18'sd0);

    always_comb
    begin
        latch_next   = latch_reg;
        counter_next = counter_reg;
        control_next = control_reg;
        run_next     = run_reg;
        reload_next  = reload_reg;
        underrun     = 1'b0;

        if (ctl.wr_lo)
        begin
            latch_next[7:0] = ctl.data;
        end
        if (ctl.wr_hi)
        begin
            latch_next[15:8] = ctl.data;
        end
        if (ctl.wr_ctrl)
        begin
            control_next = ctl.data;
            run_next     = ctl.data[CR_START];
            reload_next  = !ctl.data[CR_ONESHOT];
            if (ctl.data[CR_LOAD])
            begin
                counter_next = $signed({2'b00, latch_reg});
            end
        end
        if (ctl.tick && run_reg)
        begin
            counter_next = diff;
            if (expired)
            begin
                underrun = 1'b1;
                if (reload_reg)
                begin
                    counter_next = $signed({2'b00, latch_reg});
                end
                else
                begin
                    counter_next = 18'sd0;
                    run_next     = 1'b0;
                end
            end
        end
    end

    assign sts.count    = counter_reg[15:0];
    assign sts.control  = control_reg;
    assign sts.underrun = underrun;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg   <= '0;
            counter_reg <= '0;
            control_reg <= '0;
            run_reg     <= 1'b0;
            reload_reg  <= 1'b0;
        end
        else
        begin
            latch_reg   <= latch_next;
            counter_reg <= counter_next;
            control_reg <= control_next;
            run_reg     <= run_next;
            reload_reg  <= reload_next;
        end
    end

endmodule

// ===== design/cia_port_timer_interrupt_unit.sv =====
// Channel  Dir   Contents
// -------  ----  ---------------------------------------------------------
// req      in    command, reg_index, write_data, tick_cycles, line levels
// rsp      out   read_data, nmi_request, serial line drives, video_bank
//
// One item per cycle while rsp keeps up: the register update and the result are
// computed in the accept cycle and the result lands in the output register.
// The timer subtract/compare is the longest path.
// rst_n (async, active low) clears all ports, timers and interrupt state;
// the internal serial line state comes up released (all ones); the drives are not reset.
// A stalled result holds req.ready low until rsp takes it.
module cia_port_timer_interrupt_unit (
    input  logic         clk,
    input  logic         rst_n,
    cptiu_in_if.sink     req,
    cptiu_out_if.source  rsp
);
    import cptiu_pkg::*;

    // architectural state
    logic [7:0] pa_reg,    pa_next;
    logic [7:0] pb_reg,    pb_next;
    logic [7:0] ddra_reg,  ddra_next;
    logic [7:0] ddrb_reg,  ddrb_next;
    logic [7:0] sdr_reg,   sdr_next;
    logic [7:0] flags_reg, flags_next;
    logic [7:0] mask_reg,  mask_next;
    logic [1:0] nmi_reg,   nmi_next;
    logic [2:0] lines_reg, lines_next;

    // result register
    logic       out_valid_reg;
    logic [7:0] rd_reg,    rd_next;
    logic       nmi_out_reg;
    logic [2:0] lines_out_reg;
    logic [1:0] bank_reg;

    logic       accept;
    logic       is_wr, is_rd, is_tick;
    timer_ctl_t ctl_a, ctl_b;
    timer_sts_t sts_a, sts_b;

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign is_wr     = accept && (req.command == CMD_WRITE);
    assign is_rd     = accept && (req.command == CMD_READ);
    assign is_tick   = accept && (req.command == CMD_TICK);

    // timer write strobes
    always_comb
    begin
        ctl_a.wr_lo   = is_wr && (req.reg_index == REG_TA_LO);
        ctl_a.wr_hi   = is_wr && (req.reg_index == REG_TA_HI);
        ctl_a.wr_ctrl = is_wr && (req.reg_index == REG_CRA);
        ctl_a.tick    = is_tick;
        ctl_a.data    = req.write_data;
        ctl_a.cycles  = req.tick_cycles;
        ctl_b.wr_lo   = is_wr && (req.reg_index == REG_TB_LO);
        ctl_b.wr_hi   = is_wr && (req.reg_index == REG_TB_HI);
        ctl_b.wr_ctrl = is_wr && (req.reg_index == REG_CRB);
        ctl_b.tick    = is_tick;
        ctl_b.data    = req.write_data;
        ctl_b.cycles  = req.tick_cycles;
    end

    cptiu_timer u_timer_a (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_a),
        .sts   (sts_a)
    );

    cptiu_timer u_timer_b (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl_b),
        .sts   (sts_b)
    );

    // read mux, sampled before this item's update
    always_comb
    begin
        unique case (req.reg_index)
            REG_PRA:
            begin
                rd_next             = pa_reg;
                rd_next[PA_DATA_IN] = !req.serial_data_line;
                rd_next[PA_CLK_IN]  = !req.serial_clock_line;
            end
            REG_PRB:   rd_next = pb_reg;
            REG_DDRA:  rd_next = ddra_reg;
            REG_DDRB:  rd_next = ddrb_reg;
            REG_TA_LO: rd_next = sts_a.count[7:0];
            REG_TA_HI: rd_next = sts_a.count[15:8];
            REG_TB_LO: rd_next = sts_b.count[7:0];
            REG_TB_HI: rd_next = sts_b.count[15:8];
            REG_SDR:   rd_next = sdr_reg;
            REG_ICR:   rd_next = flags_reg;
            REG_CRA:   rd_next = sts_a.control;
            REG_CRB:   rd_next = sts_b.control;
            default:   rd_next = 8'h00;  // time-of-day window
        endcase
        if (!is_rd)
        begin
            rd_next = 8'h00;
        end
    end

    // register and interrupt updates
    always_comb
    begin
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        ddra_next  = ddra_reg;
        ddrb_next  = ddrb_reg;
        sdr_next   = sdr_reg;
        flags_next = flags_reg;
        mask_next  = mask_reg;
        nmi_next   = nmi_reg;
        lines_next = lines_reg;

        if (is_wr)
        begin
            unique case (req.reg_index)
                REG_PRA:
                begin
                    pa_next = req.write_data;
                    // only output-direction bits drive the lines
                    if (ddra_reg[PA_DATA])
                    begin
                        lines_next[0] = req.write_data[PA_DATA];
                    end
                    if (ddra_reg[PA_CLK])
                    begin
                        lines_next[1] = req.write_data[PA_CLK];
                    end
                    if (ddra_reg[PA_ATN])
                    begin
                        lines_next[2] = req.write_data[PA_ATN];
                    end
                end
                REG_PRB:  pb_next = req.write_data;
                REG_DDRA:
                begin
                    // input bits read back as pulled high
                    pa_next   = pa_reg | ~req.write_data;
                    ddra_next = req.write_data;
                end
                REG_DDRB:
                begin
                    pb_next   = ~req.write_data;
                    ddrb_next = req.write_data;
                end
                REG_SDR:  sdr_next = req.write_data;
                REG_ICR:
                begin
                    if (req.write_data[ICR_SETCLR])
                    begin
                        mask_next = mask_reg | req.write_data;
                    end
                    else
                    begin
                        mask_next = mask_reg & ~req.write_data;
                    end
                end
                default: ;  // timers handled in their own units, TOD ignored
            endcase
        end

        if (is_rd && (req.reg_index == REG_ICR))
        begin
            flags_next = 8'h00;
            nmi_next   = 2'b00;
        end

        if (sts_a.underrun)
        begin
            flags_next[ICR_TA] = 1'b1;
            if (mask_reg[ICR_TA])
            begin
                flags_next[ICR_SETCLR] = 1'b1;
                nmi_next[0]            = 1'b1;
            end
        end
        if (sts_b.underrun)
        begin
            flags_next[ICR_TB] = 1'b1;
            if (mask_reg[ICR_TB])
            begin
                flags_next[ICR_SETCLR] = 1'b1;
                nmi_next[1]            = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pa_reg        <= '0;
            pb_reg        <= '0;
            ddra_reg      <= '0;
            ddrb_reg      <= '0;
            sdr_reg       <= '0;
            flags_reg     <= '0;
            mask_reg      <= '0;
            nmi_reg       <= '0;
            lines_reg     <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pa_reg        <= pa_next;
            pb_reg        <= pb_next;
            ddra_reg      <= ddra_next;
            ddrb_reg      <= ddrb_next;
            sdr_reg       <= sdr_next;
            flags_reg     <= flags_next;
            mask_reg      <= mask_next;
            nmi_reg       <= nmi_next;
            lines_reg     <= lines_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload: read data from before this item's update, the rest from after it
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_reg        <= rd_next;
            nmi_out_reg   <= |nmi_next;
            lines_out_reg <= lines_next;
            bank_reg      <= ~pa_next[1:0];
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.read_data     = rd_reg;
    assign rsp.nmi_request   = nmi_out_reg;
    assign rsp.ser_data_out  = lines_out_reg[0];
    assign rsp.ser_clock_out = lines_out_reg[1];
    assign rsp.ser_atn_out   = lines_out_reg[2];
    assign rsp.video_bank    = bank_reg;

    // a pending NMI always shows up in the flag summary bit
    a_nmi_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (nmi_reg != 2'b00) |-> flags_reg[ICR_SETCLR])
        else $error("nmi pending without flag summary bit");

    // reading the interrupt register clears the flags and the pending NMIs
    a_icr_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (is_rd && (req.reg_index == REG_ICR)) |=>
            ((nmi_reg == 2'b00) && (flags_reg == 8'h00)))
        else $error("interrupt read did not clear flags");

    // a held result blocks new items
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("item accepted while result stalled");

    // the result reflects the NMI state left by its item
    a_nmi_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (rsp.nmi_request == (nmi_reg != 2'b00)))
        else $error("nmi_request out of step with state");

endmodule
